// ----- rtl/multitap_keypad_text_entry_assert.svh -----
// Assertion macros used by the back end of the text entry RTL
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_ASSERT_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_ASSERT_SVH

// Condition holds at every edge outside reset
`define MTE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define MTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define MTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mte_pkg.sv -----
// Types, constants and the tap table of the multi-tap text entry block
`default_nettype none

package mte_pkg;

    localparam int KEY_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 4;
    localparam int KIND_W     = 2;
    localparam int TAP_W      = 2;
    localparam int TICK_W     = 8;
    localparam int NAME_DEPTH = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KEY_W-1:0]  KEY_STAR       = 4'd10;
    localparam logic [KEY_W-1:0]  KEY_POUND      = 4'd11;
    localparam logic [CHAR_W-1:0] CHAR_CURSOR    = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_NONE      = 8'h00;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 8'd50;

    localparam logic [0:11][0:3][CHAR_W-1:0] TAP_TABLE = '{
        '{"0", "0", "0", "0"}, '{"1", "1", "1", "1"}, '{"2", "A", "B", "C"},
        '{"3", "D", "E", "F"}, '{"4", "G", "H", "I"}, '{"5", "J", "K", "L"},
        '{"6", "M", "N", "O"}, '{"7", "P", "R", "S"}, '{"8", "T", "U", "V"},
        '{"9", "W", "X", "Y"}, '{"*", "*", "*", "*"}, '{"#", "#", "#", "#"}
    };

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CHAR,
        OP_STAR,
        OP_POUND,
        OP_NONE
    } t_op_code;

    typedef struct packed {
        t_op_code         code;
        logic [KEY_W-1:0] key;
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE  = 2'd0,
        KIND_SAME    = 2'd1,
        KIND_NAME    = 2'd2,
        KIND_IGNORED = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  slot_index;
        logic [CHAR_W-1:0] slot_char;
        logic [IDX_W-1:0]  name_length;
        logic              pending;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        S_RUN,
        S_WALK,
        S_DONE
    } t_state;

    function automatic logic [CHAR_W-1:0] tap_char(input logic [KEY_W-1:0] key,
                                                   input logic [TAP_W-1:0] tap);
        logic [CHAR_W-1:0] ch;
        ch = CHAR_NONE;
        if (key <= KEY_POUND) begin
            ch = TAP_TABLE[key][tap];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mte_if.sv -----
// Channel interfaces of the text entry block: key items, results, configuration
`default_nettype none

interface mte_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [mte_pkg::KEY_W-1:0]    key_code;

    modport source(output valid, command, key_code, input ready);
    modport sink(input valid, command, key_code, output ready);
endinterface

interface mte_out_if;
    logic                         valid;
    logic                         ready;
    logic [mte_pkg::KIND_W-1:0]   kind;
    logic [mte_pkg::IDX_W-1:0]    slot_index;
    logic [mte_pkg::CHAR_W-1:0]   slot_char;
    logic [mte_pkg::IDX_W-1:0]    name_length;
    logic                         pending;
    logic                         last;

    modport source(output valid, kind, slot_index, slot_char, name_length, pending, last,
                   input ready);
    modport sink(input valid, kind, slot_index, slot_char, name_length, pending, last,
                 output ready);
endinterface

interface mte_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mte_pkg::TICK_W-1:0]   idle_timeout_ticks;

    modport source(output valid, idle_timeout_ticks, input ready);
    modport sink(input valid, idle_timeout_ticks, output ready);
endinterface

`default_nettype wire

// ----- rtl/mte_front.sv -----
// Front end: accepts key and tick transactions and classifies them into operations
`default_nettype none

module mte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mte_in_if.sink        i_in,
    output logic          o_push_valid,
    output mte_pkg::t_op  o_push_op,
    input  logic          i_push_ready
);

    logic          r_valid;
    mte_pkg::t_op  r_op;
    mte_pkg::t_op  n_op;

    always_comb begin
        n_op.key = i_in.key_code;
        if (!i_in.command) begin
            n_op.code = mte_pkg::OP_TICK;
        end else if (i_in.key_code > mte_pkg::KEY_POUND) begin
            n_op.code = mte_pkg::OP_NONE;
        end else if (i_in.key_code == mte_pkg::KEY_POUND) begin
            n_op.code = mte_pkg::OP_POUND;
        end else if (i_in.key_code == mte_pkg::KEY_STAR) begin
            n_op.code = mte_pkg::OP_STAR;
        end else begin
            n_op.code = mte_pkg::OP_CHAR;
        end
    end

    assign i_in.ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op <= n_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mte_queue.sv -----
// Short operation queue between the front end and the execution back end
`default_nettype none

module mte_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  mte_pkg::t_op  i_push_op,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output mte_pkg::t_op  o_pop_op,
    input  logic          i_pop_ready
);

    localparam int DEPTH = mte_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mte_pkg::t_op      r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mte_back.sv -----
// Back end: entry state, name store, finishing walk and the result register
`default_nettype none

`include "multitap_keypad_text_entry_assert.svh"

module mte_back #(
    parameter int MAX_NAME_LEN = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  mte_pkg::t_op  i_op,
    output logic          o_op_ready,
    mte_cfg_if.sink       i_cfg,
    mte_out_if.source     o_out
);

    localparam logic [mte_pkg::IDX_W-1:0] MAX_LEN = mte_pkg::IDX_W'(MAX_NAME_LEN);

    mte_pkg::t_state                r_state,    n_state;
    logic [mte_pkg::TICK_W-1:0]     r_timeout;
    logic [mte_pkg::KEY_W-1:0]      r_rem_key,  n_rem_key;
    logic                           r_rem_valid, n_rem_valid;
    logic [mte_pkg::TAP_W-1:0]      r_tap,      n_tap;
    logic [mte_pkg::TICK_W-1:0]     r_idle,     n_idle;
    logic [mte_pkg::IDX_W-1:0]      r_len,      n_len;
    logic                           r_pending,  n_pending;
    logic [mte_pkg::IDX_W-1:0]      r_walk,     n_walk;
    logic                           r_out_valid, n_out_valid;
    mte_pkg::t_result               r_out,      n_out;
    logic [mte_pkg::CHAR_W-1:0]     r_name_store [mte_pkg::NAME_DEPTH];
    logic [mte_pkg::CHAR_W-1:0]     r_rd_data;

    logic                           slot_free;
    logic                           load;
    logic                           mem_we;
    logic [mte_pkg::IDX_W-1:0]      mem_waddr;
    logic [mte_pkg::CHAR_W-1:0]     mem_wdata;

    assign slot_free = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        logic                        repeat_key;
        logic [mte_pkg::TAP_W-1:0]   tap_next;
        logic [mte_pkg::CHAR_W-1:0]  ch;

        n_state     = r_state;
        n_rem_key   = r_rem_key;
        n_rem_valid = r_rem_valid;
        n_tap       = r_tap;
        n_idle      = r_idle;
        n_len       = r_len;
        n_pending   = r_pending;
        n_walk      = r_walk;
        o_op_ready  = 1'b0;
        load        = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_len;
        mem_wdata   = mte_pkg::CHAR_CURSOR;

        repeat_key = r_rem_valid && (r_rem_key == i_op.key);
        tap_next   = repeat_key ? r_tap + 1'b1 : '0;
        ch         = mte_pkg::tap_char(i_op.key, tap_next);

        n_out.kind        = mte_pkg::KIND_SAME;
        n_out.slot_index  = r_len;
        n_out.slot_char   = mte_pkg::CHAR_NONE;
        n_out.name_length = r_len;
        n_out.pending     = r_pending;
        n_out.last        = 1'b1;

        case (r_state)
            mte_pkg::S_RUN: begin
                if (i_op_valid && slot_free) begin
                    o_op_ready = 1'b1;
                    load       = 1'b1;
                    if (i_op.code != mte_pkg::OP_TICK && i_op.code != mte_pkg::OP_NONE) begin
                        n_idle      = '0;
                        n_rem_key   = i_op.key;
                        n_rem_valid = 1'b1;
                        n_tap       = tap_next;
                    end
                    case (i_op.code)
                        mte_pkg::OP_TICK: begin
                            if (r_idle >= r_timeout) begin
                                n_idle      = '0;
                                n_rem_valid = 1'b0;
                                if (r_pending && (r_len < MAX_LEN)) begin
                                    // commit and put the cursor on the next slot
                                    n_len             = r_len + 1'b1;
                                    n_pending         = 1'b0;
                                    mem_we            = 1'b1;
                                    mem_waddr         = n_len;
                                    n_out.kind        = mte_pkg::KIND_UPDATE;
                                    n_out.slot_index  = n_len;
                                    n_out.slot_char   = mte_pkg::CHAR_CURSOR;
                                    n_out.name_length = n_len;
                                    n_out.pending     = 1'b0;
                                end
                            end else begin
                                n_idle = r_idle + 1'b1;
                            end
                        end
                        mte_pkg::OP_CHAR: begin
                            n_pending         = 1'b1;
                            mem_we            = 1'b1;
                            mem_wdata         = ch;
                            n_out.kind        = mte_pkg::KIND_UPDATE;
                            n_out.slot_char   = ch;
                            n_out.pending     = 1'b1;
                        end
                        mte_pkg::OP_STAR: begin
                            if (r_len != '0) begin
                                n_len             = r_len - 1'b1;
                                n_pending         = 1'b0;
                                mem_we            = 1'b1;
                                mem_waddr         = n_len;
                                n_out.kind        = mte_pkg::KIND_UPDATE;
                                n_out.slot_index  = n_len;
                                n_out.slot_char   = mte_pkg::CHAR_CURSOR;
                                n_out.name_length = n_len;
                                n_out.pending     = 1'b0;
                            end
                        end
                        mte_pkg::OP_POUND: begin
                            n_pending = 1'b0;
                            if (r_len == '0) begin
                                n_out.kind       = mte_pkg::KIND_NAME;
                                n_out.slot_index = '0;
                                n_out.pending    = 1'b0;
                                n_state          = mte_pkg::S_DONE;
                            end else begin
                                // nothing emitted now; the walk follows
                                load    = 1'b0;
                                n_walk  = '0;
                                n_state = mte_pkg::S_WALK;
                            end
                        end
                        default: begin
                            // unknown key: no change
                        end
                    endcase
                end
            end
            mte_pkg::S_WALK: begin
                if (slot_free) begin
                    load             = 1'b1;
                    n_out.kind       = mte_pkg::KIND_NAME;
                    n_out.slot_index = r_walk;
                    n_out.slot_char  = r_rd_data;
                    n_out.pending    = 1'b0;
                    n_out.last       = (r_walk == r_len - 1'b1);
                    if (n_out.last) begin
                        n_state = mte_pkg::S_DONE;
                    end else begin
                        n_walk = r_walk + 1'b1;
                    end
                end
            end
            mte_pkg::S_DONE: begin
                if (i_op_valid && slot_free) begin
                    o_op_ready = 1'b1;
                    load       = 1'b1;
                    n_out.kind = mte_pkg::KIND_IGNORED;
                end
            end
            default: begin
                n_state = mte_pkg::S_RUN;
            end
        endcase

        n_out_valid = load || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mte_pkg::S_RUN;
            r_timeout   <= mte_pkg::TIMEOUT_RESET;
            r_rem_key   <= '0;
            r_rem_valid <= 1'b0;
            r_tap       <= '0;
            r_idle      <= '0;
            r_len       <= '0;
            r_pending   <= 1'b0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rem_key   <= n_rem_key;
            r_rem_valid <= n_rem_valid;
            r_tap       <= n_tap;
            r_idle      <= n_idle;
            r_len       <= n_len;
            r_pending   <= n_pending;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.idle_timeout_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    // name store: one write port, one registered read port that follows the walk
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_name_store[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_name_store[n_walk];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.slot_index  = r_out.slot_index;
    assign o_out.slot_char   = r_out.slot_char;
    assign o_out.name_length = r_out.name_length;
    assign o_out.pending     = r_out.pending;
    assign o_out.last        = r_out.last;

    `MTE_ASSERT_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= MAX_LEN, "name length beyond limit")
    `MTE_ASSERT_IMPLY(a_walk_nonempty, i_clk, i_rst_n, r_state == mte_pkg::S_WALK, (r_len != '0) && !r_pending, "walk over an empty name or with a pending character")
    `MTE_ASSERT_NEXT(a_walk_emits, i_clk, i_rst_n, (r_state == mte_pkg::S_WALK) && slot_free, r_out_valid && (r_out.kind == mte_pkg::KIND_NAME), "walk step gave no name character")
    `MTE_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n, r_state == mte_pkg::S_DONE, (r_state == mte_pkg::S_DONE) && !r_pending, "finished entry left its final state")

endmodule

`default_nettype wire

// ----- rtl/multitap_keypad_text_entry.sv -----
// Top level of the multi-tap keypad text entry block
`default_nettype none

// Multi-tap text entry for a 12-key pad. Each input transaction is a poll tick or a key
// press; a front end registers and classifies it and places it in a two-entry queue, and
// the back end executes one operation per cycle, while the output is not stalled and no
// walk runs, into a result register. A tick or a key other than a finishing pound gives a
// single result, which passes the front register, the queue and the result register.
// Pound starts a walk over the committed characters of the name store that emits one
// character per cycle while the output is not stalled; the single read port of the name
// store paces that walk. The input keeps accepting while the queue has room.
// idle_timeout_ticks may be written whenever the block is idle.
module multitap_keypad_text_entry #(
    parameter int MAX_NAME_LEN = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mte_in_if.sink      i_in,
    mte_cfg_if.sink     i_cfg,
    mte_out_if.source   o_out
);

    logic          push_valid;
    mte_pkg::t_op  push_op;
    logic          push_ready;
    logic          pop_valid;
    mte_pkg::t_op  pop_op;
    logic          pop_ready;

    mte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_op    (push_op),
        .i_push_ready (push_ready)
    );

    mte_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_op    (push_op),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_op     (pop_op),
        .i_pop_ready  (pop_ready)
    );

    mte_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (pop_valid),
        .i_op       (pop_op),
        .o_op_ready (pop_ready),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ----- tb/multitap_keypad_text_entry_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the multi-tap keypad text entry block
module multitap_keypad_text_entry_tb;

    localparam int NAME_MAX    = 10;
    localparam int STALL_LIMIT = 3000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Four taps per key, keys 0 to 11 in order
    localparam logic [0:47][mte_pkg::CHAR_W-1:0] KEY_LETTERS =
        "000011112ABC3DEF4GHI5JKL6MNO7PRS8TUV9WXY****####";

    localparam mte_pkg::t_result NO_WANT    =
        '{mte_pkg::KIND_SAME, 4'd0, mte_pkg::CHAR_NONE, 4'd0, 1'b0, 1'b0};
    localparam mte_pkg::t_result IDLE_EMPTY =
        '{mte_pkg::KIND_SAME, 4'd0, mte_pkg::CHAR_NONE, 4'd0, 1'b0, 1'b1};
    localparam mte_pkg::t_result FIRST_TWO  =
        '{mte_pkg::KIND_UPDATE, 4'd0, "2", 4'd0, 1'b1, 1'b1};

    typedef struct packed {
        logic                       cfg_write;
        logic [mte_pkg::TICK_W-1:0] cfg_value;
        logic                       command;
        logic [mte_pkg::KEY_W-1:0]  key;
        logic                       fixed;
        mte_pkg::t_result           want;
    } t_entry_row;

    localparam t_entry_row OPENING_ROWS [26] = '{
        '{1'b0, 8'd0, CMD_TICK, 4'd0,              1'b1, IDLE_EMPTY},
        '{1'b0, 8'd0, CMD_KEY,  4'd15,             1'b1, IDLE_EMPTY},
        '{1'b0, 8'd0, CMD_KEY,  4'd12,             1'b1, IDLE_EMPTY},
        '{1'b0, 8'd0, CMD_KEY,  mte_pkg::KEY_STAR, 1'b1, IDLE_EMPTY},
        '{1'b0, 8'd0, CMD_TICK, 4'd13,             1'b0, NO_WANT},
        '{1'b1, 8'd1, CMD_TICK, 4'd0,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd2,              1'b1, FIRST_TWO},
        '{1'b0, 8'd0, CMD_KEY,  4'd2,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd2,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd2,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd2,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd7,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_TICK, 4'd6,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_TICK, 4'd9,              1'b0, NO_WANT},
        // same key after a timeout starts a fresh character
        '{1'b0, 8'd0, CMD_KEY,  4'd7,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd7,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd14,             1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd7,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  mte_pkg::KEY_STAR, 1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd9,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd9,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd0,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd1,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_TICK, 4'd15,             1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_TICK, 4'd0,              1'b0, NO_WANT},
        '{1'b0, 8'd0, CMD_KEY,  4'd8,              1'b0, NO_WANT}
    };

    localparam int PHASE_TIMEOUT [6] = '{3, 1, 12, 0, 50, 2};
    localparam int PHASE_ITEMS   [6] = '{40, 40, 25, 40, 55, 40};

    logic i_clk;
    logic i_rst_n;

    mte_in_if  in_ch();
    mte_cfg_if cfg_ch();
    mte_out_if res_ch();

    multitap_keypad_text_entry u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    // Predicted entry state
    logic                       p_done;
    logic                       p_key_valid;
    logic                       p_pending;
    logic [mte_pkg::KEY_W-1:0]  p_key;
    logic [mte_pkg::IDX_W-1:0]  p_len;
    logic [mte_pkg::TAP_W-1:0]  p_tap;
    logic [mte_pkg::TICK_W-1:0] p_idle;
    logic [mte_pkg::TICK_W-1:0] p_timeout;
    logic [mte_pkg::CHAR_W-1:0] p_name [mte_pkg::NAME_DEPTH];

    mte_pkg::t_result entry_due [$];
    int               mismatches   = 0;
    int               items_sent;
    int               quiet_cycles = 0;
    logic             calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic mte_pkg::t_result report_of(input mte_pkg::t_kind kind,
                                                   input logic [mte_pkg::IDX_W-1:0] idx,
                                                   input logic [mte_pkg::CHAR_W-1:0] ch,
                                                   input logic last);
        report_of = '{kind, idx, ch, p_len, p_pending, last};
    endfunction

    task automatic predict_entry(input logic command, input logic [mte_pkg::KEY_W-1:0] key);
        int                         i;
        logic [mte_pkg::CHAR_W-1:0] ch;
        if (p_done) begin
            entry_due.push_back(report_of(mte_pkg::KIND_IGNORED, p_len, mte_pkg::CHAR_NONE,
                                          1'b1));
        end else if (command == CMD_TICK) begin
            if (p_idle >= p_timeout) begin
                // timeout forgets the key and commits a pending character while the name is below its limit
                p_idle = '0;
                p_key_valid = 1'b0;
                if (p_pending && p_len < NAME_MAX) begin
                    p_len = p_len + 1'b1;
                    p_name[p_len] = mte_pkg::CHAR_CURSOR;
                    p_pending = 1'b0;
                    entry_due.push_back(report_of(mte_pkg::KIND_UPDATE, p_len,
                                                  mte_pkg::CHAR_CURSOR, 1'b1));
                end else begin
                    entry_due.push_back(report_of(mte_pkg::KIND_SAME, p_len,
                                                  mte_pkg::CHAR_NONE, 1'b1));
                end
            end else begin
                p_idle = p_idle + 1'b1;
                entry_due.push_back(report_of(mte_pkg::KIND_SAME, p_len, mte_pkg::CHAR_NONE,
                                              1'b1));
            end
        end else if (key > mte_pkg::KEY_POUND) begin
            entry_due.push_back(report_of(mte_pkg::KIND_SAME, p_len, mte_pkg::CHAR_NONE, 1'b1));
        end else begin
            p_idle = '0;
            if (p_key_valid && p_key == key) begin
                p_tap = p_tap + 1'b1;
            end else begin
                p_key = key;
                p_key_valid = 1'b1;
                p_tap = '0;
            end
            ch = KEY_LETTERS[{key, p_tap}];
            if (key == mte_pkg::KEY_POUND) begin
                p_done = 1'b1;
                p_pending = 1'b0;
                if (p_len == 0) begin
                    entry_due.push_back(report_of(mte_pkg::KIND_NAME, 4'd0, mte_pkg::CHAR_NONE,
                                                  1'b1));
                end else begin
                    for (i = 0; i < int'(p_len); i++) begin
                        entry_due.push_back(report_of(mte_pkg::KIND_NAME, mte_pkg::IDX_W'(i),
                                                      p_name[i], i + 1 == int'(p_len)));
                    end
                end
            end else if (key == mte_pkg::KEY_STAR) begin
                if (p_len > 0) begin
                    p_len = p_len - 1'b1;
                    p_name[p_len] = mte_pkg::CHAR_CURSOR;
                    p_pending = 1'b0;
                    entry_due.push_back(report_of(mte_pkg::KIND_UPDATE, p_len,
                                                  mte_pkg::CHAR_CURSOR, 1'b1));
                end else begin
                    entry_due.push_back(report_of(mte_pkg::KIND_SAME, p_len,
                                                  mte_pkg::CHAR_NONE, 1'b1));
                end
            end else begin
                p_name[p_len] = ch;
                p_pending = 1'b1;
                entry_due.push_back(report_of(mte_pkg::KIND_UPDATE, p_len, ch, 1'b1));
            end
        end
    endtask

    function automatic int stall_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, with valid still high
    task automatic send_item(input logic command, input logic [mte_pkg::KEY_W-1:0] key,
                             input logic fixed, input mte_pkg::t_result want);
        int   gap;
        logic taken;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : stall_span();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.command  = command;
        in_ch.key_code = key;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = in_ch.ready;
        end
        predict_entry(command, key);
        if (fixed) begin
            entry_due[entry_due.size() - 1] = want;
        end
        if (!(command == CMD_KEY && key > mte_pkg::KEY_POUND)) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (entry_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_timeout(input logic [mte_pkg::TICK_W-1:0] ticks);
        logic taken;
        drain_results();
        cfg_ch.valid              = 1'b1;
        cfg_ch.idle_timeout_ticks = ticks;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = cfg_ch.ready;
        end
        p_timeout = ticks;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // One short key sequence; a committing one taps a digit key and waits out the timeout
    task automatic send_burst(input logic commit_only);
        int                        r;
        int                        taps;
        int                        ticks;
        logic [mte_pkg::KEY_W-1:0] k;
        r = commit_only ? 0 : $urandom_range(0, 99);
        if (r < 65) begin
            k = mte_pkg::KEY_W'($urandom_range(0, 9));
            taps = $urandom_range(1, 5);
            repeat (taps) send_item(CMD_KEY, k, 1'b0, NO_WANT);
            if (commit_only || $urandom_range(0, 3) != 0) begin
                ticks = int'(p_timeout) + 1;
            end else begin
                ticks = $urandom_range(0, int'(p_timeout));
            end
            repeat (ticks) begin
                send_item(CMD_TICK, mte_pkg::KEY_W'($urandom_range(0, 15)), 1'b0, NO_WANT);
            end
        end else if (r < 78) begin
            send_item(CMD_KEY, mte_pkg::KEY_STAR, 1'b0, NO_WANT);
        end else if (r < 88) begin
            send_item(CMD_KEY, mte_pkg::KEY_W'($urandom_range(0, 9)), 1'b0, NO_WANT);
            send_item(CMD_KEY, mte_pkg::KEY_W'($urandom_range(0, 10)), 1'b0, NO_WANT);
        end else if (r < 94) begin
            send_item(CMD_KEY, mte_pkg::KEY_W'($urandom_range(12, 15)), 1'b0, NO_WANT);
        end else begin
            send_item(CMD_TICK, mte_pkg::KEY_W'($urandom_range(0, 15)), 1'b0, NO_WANT);
        end
    endtask

    initial begin : drive_ready
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0 && !calm) begin
                res_ch.ready = 1'b0;
                hold--;
            end else begin
                res_ch.ready = 1'b1;
                hold = 0;
                if (!calm && $urandom_range(0, 99) < 30) begin
                    hold = stall_span();
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        mte_pkg::t_result got;
        mte_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{mte_pkg::t_kind'(res_ch.kind), res_ch.slot_index, res_ch.slot_char,
                    res_ch.name_length, res_ch.pending, res_ch.last};
            if (entry_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected: kind %0d idx %0d char %h len %0d pend %b last %b",
                             got.kind, got.slot_index, got.slot_char, got.name_length,
                             got.pending, got.last);
                end
            end else begin
                want = entry_due.pop_front();
                if (got.kind != want.kind || got.slot_index != want.slot_index
                        || got.slot_char != want.slot_char
                        || got.name_length != want.name_length
                        || got.pending != want.pending || got.last != want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("expected: kind %0d idx %0d char %h len %0d pend %b last %b",
                                 want.kind, want.slot_index, want.slot_char,
                                 want.name_length, want.pending, want.last);
                        $display("got:      kind %0d idx %0d char %h len %0d pend %b last %b",
                                 got.kind, got.slot_index, got.slot_char, got.name_length,
                                 got.pending, got.last);
                    end
                end
            end
        end
    end

    // Drop the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("multitap_keypad_text_entry test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int ph;
        int start;
        i_rst_n                   = 1'b0;
        in_ch.valid               = 1'b0;
        in_ch.command             = CMD_TICK;
        in_ch.key_code            = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.idle_timeout_ticks = mte_pkg::TIMEOUT_RESET;
        calm                      = 1'b0;
        items_sent                = 0;
        p_done                    = 1'b0;
        p_key_valid               = 1'b0;
        p_pending                 = 1'b0;
        p_key                     = '0;
        p_len                     = '0;
        p_tap                     = '0;
        p_idle                    = '0;
        p_timeout                 = mte_pkg::TIMEOUT_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (OPENING_ROWS[i]) begin
            if (OPENING_ROWS[i].cfg_write) begin
                set_timeout(OPENING_ROWS[i].cfg_value);
            end else begin
                send_item(OPENING_ROWS[i].command, OPENING_ROWS[i].key,
                          OPENING_ROWS[i].fixed, OPENING_ROWS[i].want);
            end
        end

        for (ph = 0; ph < 6; ph++) begin
            calm = (ph == 1);
            if (ph == 3) begin
                set_timeout(mte_pkg::TICK_W'($urandom_range(2, 8)));
            end else begin
                set_timeout(mte_pkg::TICK_W'(PHASE_TIMEOUT[ph]));
            end
            start = items_sent;
            send_burst(1'b1);
            while (items_sent - start < PHASE_ITEMS[ph]) send_burst(1'b0);
        end

        // fill the name to its limit, then hold off until everything is out
        calm = 1'b0;
        set_timeout(8'd1);
        repeat (12) send_burst(1'b1);
        drain_results();
        send_item(CMD_KEY, mte_pkg::KEY_POUND, 1'b0, NO_WANT);
        repeat (8) send_item(1'($urandom_range(0, 1)), mte_pkg::KEY_W'($urandom_range(0, 15)),
                             1'b0, NO_WANT);
        in_ch.valid = 1'b0;

        while (entry_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("multitap_keypad_text_entry test passed");
        end else begin
            $display("multitap_keypad_text_entry test failed");
        end
        $finish;
    end

endmodule

// ----- multitap_keypad_text_entry.f -----
+incdir+rtl
rtl/mte_pkg.sv
rtl/mte_if.sv
rtl/mte_front.sv
rtl/mte_queue.sv
rtl/mte_back.sv
rtl/multitap_keypad_text_entry.sv
tb/multitap_keypad_text_entry_tb.sv
